FILE: hw/rtl/ccs_pkg.sv
// Shared types and byte constants of the C comment stripper.
`default_nettype none

package ccs_pkg;

  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSpace  = 8'h20;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [7:0] chr;
    logic       valid;
    logic       eol;
    logic       cmt_open;
  } ccs_res_t;

  typedef struct packed {
    logic [1:0]       cnt;
    ccs_res_t [1:0]   res;
  } ccs_pair_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ccs_scan.sv
// Scan state and per-byte result logic of the C comment stripper.
`default_nettype none

module ccs_scan (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        char_i,
  input  wire logic              has_char_i,
  input  wire logic              line_end_i,
  output ccs_pkg::ccs_pair_t     pair_o
);

  localparam logic [2:0] ModeNormal    = 3'd0;
  localparam logic [2:0] ModeLit       = 3'd1;
  localparam logic [2:0] ModeLitEsc    = 3'd2;
  localparam logic [2:0] ModeSlash     = 3'd3;
  localparam logic [2:0] ModeBlock     = 3'd4;
  localparam logic [2:0] ModeBlockStar = 3'd5;
  localparam logic [2:0] ModeLine      = 3'd6;

  typedef struct packed {
    logic [2:0] mode;
    logic       qs;
    logic       mid;
  } nb_t;

  logic [2:0] mode_q, mode_d, mode_n;
  logic       qs_q, qs_d, qs_n;
  logic       pre, mid, post;
  logic [7:0] mid_chr;
  logic [7:0] quote;
  logic [1:0] cnt;
  logic       open_end;
  nb_t        nb;

  function automatic nb_t normal_byte(input logic [7:0] c, input logic qs_in);
    nb_t r;
    r.qs = qs_in;
    if (c == ccs_pkg::ChDquote || c == ccs_pkg::ChSquote) begin
      r.qs   = (c == ccs_pkg::ChSquote);
      r.mode = ModeLit;
      r.mid  = 1'b1;
    end else if (c == ccs_pkg::ChSlash) begin
      r.mode = ModeSlash;
      r.mid  = 1'b0;
    end else begin
      r.mode = ModeNormal;
      r.mid  = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    mode_n  = mode_q;
    qs_n    = qs_q;
    pre     = 1'b0;
    mid     = 1'b0;
    mid_chr = char_i;
    quote   = qs_q ? ccs_pkg::ChSquote : ccs_pkg::ChDquote;
    nb      = normal_byte(char_i, qs_q);
    if (has_char_i) begin
      unique case (mode_q)
        ModeLit: begin
          mid = 1'b1;
          if (char_i == ccs_pkg::ChBslash) begin
            mode_n = ModeLitEsc;
          end else if (char_i == quote) begin
            mode_n = ModeNormal;
          end
        end
        ModeLitEsc: begin
          mid    = 1'b1;
          mode_n = ModeLit;
        end
        ModeSlash: begin
          if (char_i == ccs_pkg::ChSlash) begin
            mode_n = ModeLine;
          end else if (char_i == ccs_pkg::ChStar) begin
            mode_n = ModeBlock;
          end else begin
            pre    = 1'b1;
            mode_n = nb.mode;
            qs_n   = nb.qs;
            mid    = nb.mid;
          end
        end
        ModeBlock: begin
          if (char_i == ccs_pkg::ChStar) begin
            mode_n = ModeBlockStar;
          end
        end
        ModeBlockStar: begin
          if (char_i == ccs_pkg::ChSlash) begin
            mid     = 1'b1;
            mid_chr = ccs_pkg::ChSpace;
            mode_n  = ModeNormal;
          end else if (char_i != ccs_pkg::ChStar) begin
            mode_n = ModeBlock;
          end
        end
        ModeLine: begin
        end
        default: begin
          mode_n = nb.mode;
          qs_n   = nb.qs;
          mid    = nb.mid;
        end
      endcase
    end

    post     = line_end_i && (mode_n == ModeSlash);
    open_end = line_end_i && (mode_n == ModeBlock || mode_n == ModeBlockStar);
    cnt      = {1'b0, pre} + {1'b0, mid} + {1'b0, post};

    pair_o.res[0].chr      = pre ? ccs_pkg::ChSlash : (mid ? mid_chr : ccs_pkg::ChSlash);
    pair_o.res[0].valid    = 1'b1;
    pair_o.res[0].eol      = line_end_i && (cnt == 2'd1);
    pair_o.res[0].cmt_open = open_end && (cnt == 2'd1);
    pair_o.res[1].chr      = (pre && mid) ? mid_chr : ccs_pkg::ChSlash;
    pair_o.res[1].valid    = 1'b1;
    pair_o.res[1].eol      = line_end_i;
    pair_o.res[1].cmt_open = open_end;
    pair_o.cnt             = cnt;

    if (line_end_i && cnt == 2'd0) begin
      pair_o.cnt             = 2'd1;
      pair_o.res[0].chr      = 8'h00;
      pair_o.res[0].valid    = 1'b0;
      pair_o.res[0].eol      = 1'b1;
      pair_o.res[0].cmt_open = open_end;
    end

    mode_d = line_end_i ? ModeNormal : mode_n;
    qs_d   = line_end_i ? 1'b0 : qs_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      qs_q   <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      qs_q   <= qs_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ccs_fifo.sv
// Result buffer that takes up to two words per cycle and sends one per cycle while pop_ready_i is high.
`default_nettype none

module ccs_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  ccs_pkg::ccs_pair_t       pair_i,
  output logic                     ready_o,
  output logic                     valid_o,
  input  wire logic                pop_ready_i,
  output ccs_pkg::ccs_res_t        data_o
);

  ccs_pkg::ccs_res_t mem [ccs_pkg::FifoDepth];

  logic [ccs_pkg::PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_1;
  logic [ccs_pkg::CntW-1:0] count_q, count_d;
  logic [1:0]               n_push;
  logic                     pop;

  assign n_push   = push_i ? pair_i.cnt : 2'd0;
  assign pop      = valid_o && pop_ready_i;
  assign wr_ptr_1 = wr_ptr_q + ccs_pkg::PtrW'(1);
  assign wr_ptr_d = wr_ptr_q + ccs_pkg::PtrW'(n_push);
  assign rd_ptr_d = rd_ptr_q + ccs_pkg::PtrW'(pop);
  assign count_d  = count_q + ccs_pkg::CntW'(n_push) - ccs_pkg::CntW'(pop);

  assign ready_o = (count_q <= ccs_pkg::CntW'(ccs_pkg::FifoDepth - 2));
  assign valid_o = (count_q != '0);
  assign data_o  = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr_q] <= pair_i.res[0];
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr_1] <= pair_i.res[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/c_comment_stripper.sv
// Top level of the C comment stripper: scan logic feeding a result buffer.
//
//  channel  dir  tdata            tuser                        tlast
//  s_axis   in   char_in          has_char                     line_end
//  m_axis   out  char_out         char_valid, comment_open     end_of_line
//
//  One input word is taken per cycle while the result buffer has room for two words.
//  A word yields zero to two result words; results leave at one word per cycle unless
//  m_axis stalls, so the output port sets the sustained input rate when words expand to two.
//  Results are registered in the result buffer before they leave on m_axis.
//  Reset clears the scan mode to normal text and empties the buffer.
//  A stall on m_axis drops s_axis_tready_o once three of the four buffer words are held.
`default_nettype none

module c_comment_stripper (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] char_in
  input  wire logic       s_axis_tuser_i,   // [0] has_char
  input  wire logic       s_axis_tlast_i,
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] char_out
  output logic [1:0]      m_axis_tuser_o,   // [0] char_valid, [1] comment_open
  output logic            m_axis_tlast_o
);

  ccs_pkg::ccs_pair_t pair;
  ccs_pkg::ccs_res_t  head;
  logic               step;

  assign step = s_axis_tvalid_i && s_axis_tready_o;

  ccs_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .char_i     (s_axis_tdata_i),
    .has_char_i (s_axis_tuser_i),
    .line_end_i (s_axis_tlast_i),
    .pair_o     (pair)
  );

  ccs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .pair_i      (pair),
    .ready_o     (s_axis_tready_o),
    .valid_o     (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .data_o      (head)
  );

  assign m_axis_tdata_o = head.chr;
  assign m_axis_tuser_o = {head.cmt_open, head.valid};
  assign m_axis_tlast_o = head.eol;

endmodule

`default_nettype wire

FILE: hw/rtl/ccs_checker.sv
// Port-level checks of the C comment stripper and their bind.
`default_nettype none

module ccs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic       s_axis_tlast_i,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic [1:0] m_axis_tuser_o,
  input wire logic       m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  a_full_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input blocked with no output pending");

  a_line_end_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> m_axis_tvalid_o)
    else $error("line end produced no output word");

  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tlast_o && m_axis_tdata_o == 8'h00)
    else $error("bare marker without line end or with data");

endmodule

bind c_comment_stripper ccs_checker u_ccs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Testbench for c_comment_stripper: directed and random lines checked against a line scanner.
module tb;

  typedef enum logic [2:0] {
    SCAN_TEXT,
    SCAN_LIT,
    SCAN_LIT_ESC,
    SCAN_SLASH,
    SCAN_BLOCK,
    SCAN_BLOCK_STAR,
    SCAN_LINE
  } scan_e;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned PhaseItems = 255;

  logic       clk;
  logic       rst_n;
  logic       s_valid;
  logic       s_ready;
  logic [7:0] s_data;   // [7:0] char_in
  logic       s_user;   // [0] has_char
  logic       s_last;
  logic       m_valid;
  logic       m_ready = 1'b0;
  logic [7:0] m_data;   // [7:0] char_out
  logic [1:0] m_user;   // [0] char_valid, [1] comment_open
  logic       m_last;

  scan_e              scan_mode;
  logic               single_quote;
  logic [7:0]         kept_bytes[$];
  logic [7:0]         line_bytes[$];
  ccs_pkg::ccs_res_t  expected_words[$];
  int                 mismatch_count;
  int                 items_sent;
  int unsigned        quiet_cycles = 0;
  int unsigned        src_idle_pct;
  int unsigned        sink_stall_pct;

  c_comment_stripper DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void text_byte(input logic [7:0] c);
    if (c == ccs_pkg::ChDquote || c == ccs_pkg::ChSquote) begin
      single_quote = (c == ccs_pkg::ChSquote);
      scan_mode = SCAN_LIT;
      kept_bytes.push_back(c);
    end else if (c == ccs_pkg::ChSlash) begin
      scan_mode = SCAN_SLASH;
    end else begin
      scan_mode = SCAN_TEXT;
      kept_bytes.push_back(c);
    end
  endfunction

  function automatic void strip_predict(input logic [7:0] c, input logic has,
                                        input logic eol_in);
    logic [7:0]        quote;
    logic              open_at_end;
    ccs_pkg::ccs_res_t r;
    quote = single_quote ? ccs_pkg::ChSquote : ccs_pkg::ChDquote;
    open_at_end = 1'b0;
    kept_bytes.delete();
    if (has) begin
      case (scan_mode)
        SCAN_LIT: begin
          kept_bytes.push_back(c);
          if (c == ccs_pkg::ChBslash) scan_mode = SCAN_LIT_ESC;
          else if (c == quote) scan_mode = SCAN_TEXT;
        end
        SCAN_LIT_ESC: begin
          kept_bytes.push_back(c);
          scan_mode = SCAN_LIT;
        end
        SCAN_SLASH: begin
          if (c == ccs_pkg::ChSlash) begin
            scan_mode = SCAN_LINE;
          end else if (c == ccs_pkg::ChStar) begin
            scan_mode = SCAN_BLOCK;
          end else begin
            kept_bytes.push_back(ccs_pkg::ChSlash);
            text_byte(c);
          end
        end
        SCAN_BLOCK: begin
          if (c == ccs_pkg::ChStar) scan_mode = SCAN_BLOCK_STAR;
        end
        SCAN_BLOCK_STAR: begin
          if (c == ccs_pkg::ChSlash) begin
            kept_bytes.push_back(ccs_pkg::ChSpace);
            scan_mode = SCAN_TEXT;
          end else if (c != ccs_pkg::ChStar) begin
            scan_mode = SCAN_BLOCK;
          end
        end
        SCAN_LINE: ;
        default: text_byte(c);
      endcase
    end
    if (eol_in) begin
      if (scan_mode == SCAN_SLASH) kept_bytes.push_back(ccs_pkg::ChSlash);
      open_at_end = (scan_mode == SCAN_BLOCK || scan_mode == SCAN_BLOCK_STAR);
      if (kept_bytes.size() == 0) begin
        r = '{chr: 8'h00, valid: 1'b0, eol: 1'b1, cmt_open: open_at_end};
        expected_words.push_back(r);
      end
    end
    foreach (kept_bytes[k]) begin
      r.chr = kept_bytes[k];
      r.valid = 1'b1;
      r.eol = eol_in && (k == kept_bytes.size() - 1);
      r.cmt_open = r.eol && open_at_end;
      expected_words.push_back(r);
    end
    if (eol_in) begin
      scan_mode = SCAN_TEXT;
      single_quote = 1'b0;
    end
  endfunction

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(5, 0))
      0: return ccs_pkg::ChSlash;
      1: return ccs_pkg::ChStar;
      2: return $urandom_range(1, 0) ? ccs_pkg::ChSquote : ccs_pkg::ChDquote;
      3: return ccs_pkg::ChBslash;
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  task automatic send_word(input logic [7:0] c, input logic has, input logic eol_in);
    @(negedge clk);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      s_valid = 1'b0;
      @(negedge clk);
    end
    s_valid = 1'b1;
    s_data = c;
    s_user = has;
    s_last = eol_in;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    strip_predict(c, has, eol_in);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b1, i == s.len() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_valid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_random_line();
    int       n;
    logic     end_on_byte;
    logic [7:0] q;
    line_bytes.delete();
    if ($urandom_range(9, 0) == 0) begin
      repeat ($urandom_range(8, 0)) line_bytes.push_back(pick_byte());
    end else begin
      repeat ($urandom_range(4, 0)) begin
        n = $urandom_range(4, 0);
        case ($urandom_range(7, 0))
          0, 1: line_bytes.push_back(8'($urandom_range(255, 0)));
          2: begin
            q = $urandom_range(1, 0) ? ccs_pkg::ChSquote : ccs_pkg::ChDquote;
            line_bytes.push_back(q);
            repeat (n) begin
              if ($urandom_range(3, 0) == 0) line_bytes.push_back(ccs_pkg::ChBslash);
              line_bytes.push_back(pick_byte());
            end
            if ($urandom_range(4, 0) != 0) line_bytes.push_back(q);
          end
          3: begin
            line_bytes.push_back(ccs_pkg::ChSlash);
            line_bytes.push_back(ccs_pkg::ChStar);
            repeat (n) line_bytes.push_back(pick_byte());
            if ($urandom_range(3, 0) != 0) begin
              line_bytes.push_back(ccs_pkg::ChStar);
              line_bytes.push_back(ccs_pkg::ChSlash);
            end
          end
          4: begin
            line_bytes.push_back(ccs_pkg::ChSlash);
            line_bytes.push_back(ccs_pkg::ChSlash);
            repeat (n) line_bytes.push_back(pick_byte());
          end
          5: line_bytes.push_back(ccs_pkg::ChSlash);
          6: line_bytes.push_back(ccs_pkg::ChStar);
          default: line_bytes.push_back(ccs_pkg::ChSpace);
        endcase
      end
    end
    end_on_byte = (line_bytes.size() != 0) && ($urandom_range(3, 0) != 0);
    foreach (line_bytes[i]) begin
      if ($urandom_range(19, 0) == 0) send_word(8'($urandom_range(255, 0)), 1'b0, 1'b0);
      send_word(line_bytes[i], 1'b1, end_on_byte && (i == line_bytes.size() - 1));
    end
    if (!end_on_byte) send_word(8'($urandom_range(255, 0)), 1'b0, 1'b1);
  endtask

  task automatic test_byte_extremes();
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b1);
    send_word(8'hA5, 1'b0, 1'b0);
    send_word(8'h5A, 1'b0, 1'b1);
  endtask

  task automatic test_literals();
    send_text("\"\\\"'");
    send_text("'\"'/");
  endtask

  task automatic test_comments();
    send_text("/*/**/");
    send_text("/x/*");
    send_text("//q");
  endtask

  task automatic test_random(input int n_items);
    int   target;
    logic paused;
    target = items_sent + n_items;
    paused = 1'b0;
    while (items_sent < target) begin
      if (!paused && items_sent >= target - n_items / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      send_random_line();
    end
  endtask

  always @(negedge clk) m_ready <= ($urandom_range(99, 0) >= sink_stall_pct);

  always @(posedge clk) begin : check_words
    ccs_pkg::ccs_res_t want;
    if (rst_n && m_valid && m_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word data %h user %b last %b", $time, m_data, m_user, m_last);
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("char_out", want.chr, m_data);
        check_field("char_valid", 8'(want.valid), 8'(m_user[0]));
        check_field("end_of_line", 8'(want.eol), 8'(m_last));
        check_field("comment_open", 8'(want.cmt_open), 8'(m_user[1]));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    s_valid = 1'b0;
    s_data = 8'h00;
    s_user = 1'b0;
    s_last = 1'b0;
    rst_n = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    mismatch_count = 0;
    items_sent = 0;
    scan_mode = SCAN_TEXT;
    single_quote = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_byte_extremes();
    test_literals();
    test_comments();
    wait_drained();

    test_random(PhaseItems);
    wait_drained();
    src_idle_pct = 70;
    test_random(PhaseItems);
    wait_drained();
    src_idle_pct = 0;
    sink_stall_pct = 70;
    test_random(PhaseItems);
    wait_drained();
    src_idle_pct = 38;
    sink_stall_pct = 38;
    test_random(PhaseItems);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
